// ----- hdl/free_page_list_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// free_page_list_allocator_assert.svh
// Assertion macros for the free page list allocator.
// ----------------------------------------------------------------------------
`ifndef FREE_PAGE_LIST_ALLOCATOR_ASSERT_SVH
`define FREE_PAGE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Antecedent true implies consequent true in the same cycle
`define FPLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent true implies consequent true in the next cycle
`define FPLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define FPLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FPLA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/fpla_pkg.sv -----
// ----------------------------------------------------------------------------
// fpla_pkg
// Shared constants, codes and controller/datapath interface types for the
// free page list allocator.
// ----------------------------------------------------------------------------
package fpla_pkg;

    // Table geometry
    localparam int MAX_PAGES     = 4096;
    localparam int INITIAL_PAGES = 256;
    localparam int INIT_COUNT    = (INITIAL_PAGES > MAX_PAGES) ? MAX_PAGES : INITIAL_PAGES;
    localparam int PAGE_W        = 12;
    localparam int COUNT_W       = 13;
    localparam int ADDR_W        = $clog2(MAX_PAGES);

    // Command codes on the input channel
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_PAGE = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_GROW,
        S_SETTLE,
        S_POP
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;      // latch the input transaction
        logic grow_init;   // load the link walk for a doubling
        logic step;        // write one link and move the walk down
        logic do_free;     // push the latched page
        logic do_bad;      // report a bad page
        logic do_nospace;  // report no space to grow
        logic do_pop;      // pop the head and report it
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_free;     // latched command is a free
        logic bad_page;    // latched page is 0 or not below the count
        logic empty;       // free list is empty
        logic no_space;    // doubling would pass the capacity
        logic last;        // walk is at its final entry
        logic out_free;    // output register can take a result
    } t_dp_sts;

endpackage

// ----- hdl/fpla_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpla_ctrl
// Sequencing state machine: clearing pass, command decode, growth walk and
// result hand-off.
// ----------------------------------------------------------------------------
module fpla_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fpla_pkg::t_dp_sts i_sts,
    output fpla_pkg::t_dp_cmd o_cmd
);

    fpla_pkg::t_state r_state;
    fpla_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpla_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fpla_pkg::S_CLEAR: begin
                if (i_sts.last) n_state = fpla_pkg::S_IDLE;
            end
            fpla_pkg::S_IDLE: begin
                if (i_in_valid) n_state = fpla_pkg::S_EXEC;
            end
            fpla_pkg::S_EXEC: begin
                if (!i_sts.is_free && i_sts.empty && !i_sts.no_space) begin
                    n_state = fpla_pkg::S_GROW;
                end else if (i_sts.out_free) begin
                    n_state = fpla_pkg::S_IDLE;
                end
            end
            fpla_pkg::S_GROW: begin
                if (i_sts.last) n_state = fpla_pkg::S_SETTLE;
            end
            fpla_pkg::S_SETTLE: begin
                n_state = fpla_pkg::S_POP;
            end
            fpla_pkg::S_POP: begin
                if (i_sts.out_free) n_state = fpla_pkg::S_IDLE;
            end
            default: begin
                n_state = fpla_pkg::S_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            fpla_pkg::S_CLEAR: begin
                o_cmd.step = 1'b1;
            end
            fpla_pkg::S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            fpla_pkg::S_EXEC: begin
                if (i_sts.is_free) begin
                    o_cmd.do_bad  = i_sts.out_free && i_sts.bad_page;
                    o_cmd.do_free = i_sts.out_free && !i_sts.bad_page;
                end else if (i_sts.empty) begin
                    o_cmd.do_nospace = i_sts.out_free && i_sts.no_space;
                    o_cmd.grow_init  = !i_sts.no_space;
                end else begin
                    o_cmd.do_pop = i_sts.out_free;
                end
            end
            fpla_pkg::S_GROW: begin
                o_cmd.step = 1'b1;
            end
            fpla_pkg::S_SETTLE: begin
                o_cmd = '0;
            end
            fpla_pkg::S_POP: begin
                o_cmd.do_pop = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- hdl/fpla_datapath.sv -----
// ----------------------------------------------------------------------------
// fpla_datapath
// Link table, free list head, page count, link walk counter and the
// registered result stage.
// ----------------------------------------------------------------------------
module fpla_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fpla_pkg::t_dp_cmd             i_cmd,
    output fpla_pkg::t_dp_sts             o_sts,
    input  logic                          i_command,
    input  logic [fpla_pkg::PAGE_W-1:0]   i_page_number,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fpla_pkg::PAGE_W-1:0]   o_page_number_res,
    output logic [1:0]                    o_status,
    output logic [fpla_pkg::COUNT_W-1:0]  o_page_count
);

    localparam int PW = fpla_pkg::PAGE_W;
    localparam int CW = fpla_pkg::COUNT_W;
    localparam int AW = fpla_pkg::ADDR_W;

    // Link table
    logic [PW-1:0] r_mem [fpla_pkg::MAX_PAGES];
    logic [PW-1:0] r_rdata;

    // List state
    logic [PW-1:0] r_head;
    logic [CW-1:0] r_total;

    // Latched transaction
    logic          r_cmd;
    logic [PW-1:0] r_page;

    // Link walk: counts down from r_cnt to r_bound
    logic [AW-1:0] r_cnt;
    logic [AW-1:0] r_bound;

    // Result stage
    logic          r_out_valid;
    logic [PW-1:0] r_res_page;
    fpla_pkg::t_status r_res_status;
    logic [CW-1:0] r_res_count;

    logic [CW:0]   s_grown;
    logic [CW-1:0] s_grown_lo;
    logic          s_out_load;
    logic          s_last;
    logic          s_wr_en;
    logic [AW-1:0] s_wr_addr;
    logic [PW-1:0] s_wr_data;

    assign s_grown    = {r_total, 1'b0};
    assign s_grown_lo = s_grown[CW-1:0];
    assign s_last     = (r_cnt == r_bound);
    assign s_out_load = i_cmd.do_free | i_cmd.do_bad | i_cmd.do_nospace | i_cmd.do_pop;

    // Status toward the controller
    always_comb begin
        o_sts.is_free  = (r_cmd == fpla_pkg::CMD_FREE);
        o_sts.bad_page = (r_page == '0) || ({1'b0, r_page} >= r_total);
        o_sts.empty    = (r_head == '0);
        o_sts.no_space = (s_grown > (CW+1)'(fpla_pkg::MAX_PAGES));
        o_sts.last     = s_last;
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    // Table write port: walk entries or a pushed page
    always_comb begin
        s_wr_en   = i_cmd.step | i_cmd.do_free;
        s_wr_addr = r_cnt;
        s_wr_data = s_last ? '0 : PW'(r_cnt - 1'b1);
        if (i_cmd.do_free) begin
            s_wr_addr = AW'(r_page);
            s_wr_data = r_head;
        end
    end

    // Link table write and registered read at the head
    always_ff @(posedge i_clk) begin
        if (s_wr_en) r_mem[s_wr_addr] <= s_wr_data;
        r_rdata <= r_mem[AW'(r_head)];
    end

    // Latch the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd  <= i_command;
            r_page <= i_page_number;
        end
    end

    // Walk counter; reset starts the clearing pass over the initial pages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= AW'(fpla_pkg::INIT_COUNT - 1);
            r_bound <= '0;
        end else if (i_cmd.grow_init) begin
            r_cnt   <= AW'(s_grown_lo - 1'b1);
            r_bound <= AW'(r_total);
        end else if (i_cmd.step && !s_last) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Head and page count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= PW'(fpla_pkg::INIT_COUNT - 1);
            r_total <= CW'(fpla_pkg::INIT_COUNT);
        end else if (i_cmd.step && s_last && (r_bound != '0)) begin
            // growth done: the new top page heads the list
            r_total <= s_grown_lo;
            r_head  <= PW'(s_grown_lo - 1'b1);
        end else if (i_cmd.do_free) begin
            r_head <= r_page;
        end else if (i_cmd.do_pop) begin
            r_head <= r_rdata;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (s_out_load) begin
            r_res_page   <= i_cmd.do_pop ? r_head : '0;
            r_res_count  <= r_total;
            r_res_status <= i_cmd.do_bad     ? fpla_pkg::ST_BAD_PAGE :
                            i_cmd.do_nospace ? fpla_pkg::ST_NO_SPACE :
                                               fpla_pkg::ST_OK;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_page_number_res = r_res_page;
    assign o_status          = r_res_status;
    assign o_page_count      = r_res_count;

endmodule

// ----- hdl/free_page_list_allocator.sv -----
// ----------------------------------------------------------------------------
// free_page_list_allocator
// LIFO free page list over a single table of next links, with growth by
// doubling and status reporting for exhausted capacity and bad frees.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the initial pages that
// writes the initial links into the table; it takes no transaction until
// that pass ends. One transaction is in flight at a time. A free, a bad free,
// a no-space allocate and an allocate from a non-empty list each take an
// accept, then one step that updates the table or head as needed and loads
// the result register once a stalled receiver has let the register go. An
// allocate that finds the list empty and doubles the page count walks the
// new links one table write per cycle, then settles the head read and pops.
// The result register parts the two channels: a new transaction is accepted
// while the previous result still waits to be taken.
// ----------------------------------------------------------------------------
`include "free_page_list_allocator_assert.svh"

module free_page_list_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [fpla_pkg::PAGE_W-1:0]   i_page_number,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fpla_pkg::PAGE_W-1:0]   o_page_number_res,
    output logic [1:0]                    o_status,
    output logic [fpla_pkg::COUNT_W-1:0]  o_page_count
);

    fpla_pkg::t_dp_cmd s_cmd;
    fpla_pkg::t_dp_sts s_sts;
    logic              s_in_acc;

    assign s_in_acc = i_in_valid && !o_in_stall;

    // Controller
    fpla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    // Datapath
    fpla_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (s_cmd),
        .o_sts             (s_sts),
        .i_command         (i_command),
        .i_page_number     (i_page_number),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_page_number_res (o_page_number_res),
        .o_status          (o_status),
        .o_page_count      (o_page_count)
    );

    // One transaction in flight: an accept is followed by a stalled input
    `FPLA_ASSERT_NEXT(a_single_flight, i_clk, i_rst_n, s_in_acc, o_in_stall)

    // Allocated pages always lie inside the current page count
    `FPLA_ASSERT_IMPLY(a_page_in_range, i_clk, i_rst_n,
        o_out_valid && (o_status == fpla_pkg::ST_OK) && (o_page_number_res != '0),
        {1'b0, o_page_number_res} < o_page_count)

    // Error results never carry a page
    `FPLA_ASSERT_IMPLY(a_error_no_page, i_clk, i_rst_n,
        o_out_valid && (o_status != fpla_pkg::ST_OK),
        o_page_number_res == '0)

endmodule

// ----- test/tb_free_page_list_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_free_page_list_allocator
// Self-checking testbench for the free page list allocator. A scoreboard keeps
// its own copy of the link table, list head and page count, predicts the
// result of every accepted transaction and checks each result in order.
// Stimulus runs a short directed sequence and then random alloc/free traffic
// under several idle patterns, letting the table grow by doubling. It ends
// with double frees and then mixed allocs and random frees.
// ----------------------------------------------------------------------------
module tb_free_page_list_allocator;

    localparam int PW    = fpla_pkg::PAGE_W;
    localparam int CW    = fpla_pkg::COUNT_W;
    localparam int MAXP  = fpla_pkg::MAX_PAGES;
    localparam int INITC = fpla_pkg::INIT_COUNT;

    // Expected result of one transaction
    typedef struct {
        logic [PW-1:0]     page;
        fpla_pkg::t_status status;
        logic [CW-1:0]     count;
    } t_page_result;

    // Predicts allocator results and checks the block's results against them
    class t_page_scoreboard;
        logic [PW-1:0]  link_tbl [MAXP];
        logic [PW-1:0]  head;
        logic [CW-1:0]  count;
        t_page_result   expected_q [$];
        int             errors;

        function new();
            link_tbl[0] = '0;
            for (int i = 1; i < MAXP; i++) link_tbl[i] = PW'(i - 1);
            count  = CW'(INITC);
            head   = PW'(INITC - 1);
            errors = 0;
        endfunction

        // Apply one accepted transaction and queue its result
        function t_page_result note_command(logic cmd, logic [PW-1:0] page);
            t_page_result res;
            int           grown;
            res.page   = '0;
            res.status = fpla_pkg::ST_OK;
            if (cmd == fpla_pkg::CMD_ALLOC) begin
                // empty list: double the table, chain new pages high to low
                if (head == '0) begin
                    grown = 2 * int'(count);
                    if (grown > MAXP) begin
                        res.status = fpla_pkg::ST_NO_SPACE;
                    end else begin
                        for (int i = grown - 1; i > int'(count); i--)
                            link_tbl[i] = PW'(i - 1);
                        link_tbl[count] = '0;
                        count = CW'(grown);
                        head  = PW'(grown - 1);
                    end
                end
                if (res.status == fpla_pkg::ST_OK) begin
                    res.page = head;
                    head     = link_tbl[head];
                end
            end else if (page == '0 || {1'b0, page} >= count) begin
                res.status = fpla_pkg::ST_BAD_PAGE;
            end else begin
                // push, no check for a page already on the list
                link_tbl[page] = head;
                head           = page;
            end
            res.count = count;
            expected_q.insert(expected_q.size(), res);
            return res;
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(logic [PW-1:0] page, logic [1:0] status,
                                   logic [CW-1:0] cnt);
            t_page_result exp_res;
            if (expected_q.size() == 0) begin
                errors++;
                $error("unexpected result: page %0d status %0d count %0d",
                       page, status, cnt);
                return;
            end
            exp_res = expected_q.pop_front();
            if (page !== exp_res.page) begin
                errors++;
                $error("page_number_res: expected %0d, got %0d", exp_res.page, page);
            end
            if (status !== exp_res.status) begin
                errors++;
                $error("status: expected %0d, got %0d", exp_res.status, status);
            end
            if (cnt !== exp_res.count) begin
                errors++;
                $error("page_count: expected %0d, got %0d", exp_res.count, cnt);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                i_command     = fpla_pkg::CMD_ALLOC;
    logic [PW-1:0]       i_page_number = '0;
    logic                i_out_stall   = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [PW-1:0]       o_page_number_res;
    logic [1:0]          o_status;
    logic [CW-1:0]       o_page_count;

    t_page_scoreboard     sb;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   hold_req      = 0;
    int                   hold_left     = 0;
    logic [PW-1:0]        out_pages [$];      // pages handed out and not yet freed
    bit                   page_out [MAXP];

    free_page_list_allocator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_page_number     (i_page_number),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_page_number_res (o_page_number_res),
        .o_status          (o_status),
        .o_page_count      (o_page_count)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Result side: check at the rising edge, set stall at the falling edge
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_result(o_page_number_res, o_status, o_page_count);
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Offer one transaction and wait until it is taken
    task automatic send_item(input logic cmd, input logic [PW-1:0] page,
                             output t_page_result res);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_page_number <= page;
        do @(posedge i_clk); while (o_in_stall);
        res = sb.note_command(cmd, page);
    endtask

    task automatic do_alloc();
        t_page_result res;
        send_item(fpla_pkg::CMD_ALLOC, PW'($urandom), res);
        if (res.status == fpla_pkg::ST_OK) begin
            out_pages.insert(out_pages.size(), res.page);
            page_out[res.page] = 1'b1;
        end
    endtask

    task automatic do_free(input logic [PW-1:0] page);
        t_page_result res;
        send_item(fpla_pkg::CMD_FREE, page, res);
        if (res.status == fpla_pkg::ST_OK && page_out[page]) begin
            page_out[page] = 1'b0;
            for (int i = 0; i < out_pages.size(); i++) begin
                if (out_pages[i] == page) begin
                    out_pages.delete(i);
                    break;
                end
            end
        end
    endtask

    // Mostly allocs and frees of handed-out pages, some bad frees
    task automatic random_item(input int alloc_pct);
        logic [PW-1:0] page;
        int            roll;
        roll = $urandom_range(99);
        if (roll < alloc_pct) begin
            do_alloc();
        end else if (roll < alloc_pct + (100 - alloc_pct) * 4 / 5 && out_pages.size() > 0) begin
            do_free(out_pages[$urandom_range(out_pages.size() - 1)]);
        end else begin
            // a legal page here could already be free; keep the list loop-free
            page = PW'($urandom);
            if (page != '0 && {1'b0, page} < sb.count) page = '0;
            do_free(page);
        end
    endtask

    // Stimulus
    initial begin
        logic [PW-1:0] dup_page;
        sb = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: pops, re-free, bad frees at the edges of the range
        do_alloc();
        do_alloc();
        do_free(PW'(INITC - 1));
        do_alloc();
        do_free('0);
        do_free(PW'(INITC));
        do_free('1);
        do_free(PW'(INITC - 1));
        do_free(PW'(INITC - 2));

        // long receiver hold-off while transactions keep coming
        hold_req = 200;
        repeat (8) random_item(60);

        // random traffic, drifting toward allocs so the table grows
        send_idle_pct = 27;
        recv_idle_pct = 48;
        repeat (520) random_item(75);
        send_idle_pct = 48;
        recv_idle_pct = 27;
        repeat (520) random_item(70);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (510) random_item(70);

        // double frees: the list may now hand out a page twice or loop
        send_idle_pct = 27;
        recv_idle_pct = 48;
        dup_page = out_pages[$urandom_range(out_pages.size() - 1)];
        do_free(dup_page);
        do_free(dup_page);
        repeat (3) do_alloc();
        repeat (40) begin
            if ($urandom_range(1) == 0) do_alloc();
            else do_free(PW'($urandom));
        end

        // drain and finish
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
